// File: src/csp_pkg.sv
// Shared constants, types and state codes of the circular shift profile match unit.
`default_nettype none
package csp_pkg;

  localparam int MAX_BINS      = 64;
  localparam int IDX_W         = 6;
  localparam int CNT_W         = 7;
  localparam int RANGE_BITS    = 16;
  localparam int BIN_W         = RANGE_BITS + 1;
  localparam int ERR_W         = RANGE_BITS + IDX_W;
  localparam int PROD_W        = ERR_W + CNT_W;
  localparam int DEN_W         = 18;
  localparam int DIV_W         = DEN_W + 10;
  localparam int DIV_CNT_W     = 5;
  localparam int SCORE_W       = 11;
  localparam int YAW_W         = 16;
  localparam int FULL_SCALE_MM = 3000;
  localparam int YAW_FULL      = 36000;
  localparam int Q10_SHIFT     = 10;
  localparam int SIXTH_RECIP   = 43;
  localparam int SIXTH_SHIFT   = 8;
  localparam int IN_W          = 40;
  localparam int OUT_W         = 48;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_DRAIN,
    ST_DEN,
    ST_SINIT,
    ST_SDIV,
    ST_YINIT,
    ST_YDIV,
    ST_SEND
  } state_t;

endpackage
`default_nettype wire

// File: src/circular_shift_profile_match_unit.sv
// Top level of the circular shift profile match unit.
// Bins stream in one per transfer and are written to two bin memories (first and
// second profile); the transfer with tlast closes the frame and bins beyond 64 are
// dropped. For N stored bins the search then reads both memories once per cycle,
// one bin pair per cycle for each of the N shifts, and then drains its pipeline; a
// shared 28-step restoring divider then derives the score and the yaw. The search
// rate is set by the single read port of each bin memory. Input is not taken during
// the search; the result waits in an output register while the next frame loads.
`default_nettype none
module circular_shift_profile_match_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output      logic                      s_tready,
  // range_a[15:0], hit_a[16], range_b[32:17], hit_b[33], zero[39:34]
  input  wire logic [csp_pkg::IN_W-1:0]  s_tdata,
  input  wire logic                      s_tlast,
  output      logic                      m_tvalid,
  input  wire logic                      m_tready,
  // matched[0], score_q10[11:1], best_shift[17:12], yaw_centideg[33:18],
  // overlap_bins[40:34], usable[41], zero[47:42]
  output      logic [csp_pkg::OUT_W-1:0] m_tdata,
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic [csp_pkg::CNT_W-1:0] cfg_data
);
  import csp_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0]   min_overlap;
  logic [CNT_W-1:0]   bins_loaded;
  logic [CNT_W-1:0]   frame_cnt;
  logic               in_xfer;
  logic               wr_en;
  logic [BIN_W-1:0]   a_wdata, b_wdata, a_q, b_q;

  logic [IDX_W-1:0]   c_idx, s_idx, bc_idx;
  logic               c_last, s_last, bc_last;
  logic               rd_vld, rd_last;
  logic [IDX_W-1:0]   rd_shift;

  logic [RANGE_BITS-1:0] diff;
  logic               both_hit;
  logic [ERR_W-1:0]   acc_err, acc_err_sum;
  logic [CNT_W-1:0]   acc_n, acc_n_sum;

  logic               cand_vld;
  logic [ERR_W-1:0]   cand_err;
  logic [CNT_W-1:0]   cand_n;
  logic [IDX_W-1:0]   cand_shift;
  logic [CNT_W-1:0]   min_n;
  logic [PROD_W-1:0]  prod_cand, prod_best;
  logic               cand_ok;

  logic               found;
  logic [ERR_W-1:0]   best_err;
  logic [CNT_W-1:0]   best_n;
  logic [IDX_W-1:0]   best_s;

  logic [DEN_W-1:0]   den;
  logic [DEN_W-1:0]   div_den;
  logic [DEN_W-1:0]   div_rem;
  logic [DIV_W-1:0]   div_dq;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DEN_W:0]     rem_sh;
  logic               rem_ge;
  logic [DEN_W-1:0]   rem_step;
  logic [SCORE_W-1:0] res_score;
  logic [YAW_W-1:0]   res_yaw;
  logic               send_ok;
  logic [CNT_W+4:0]   sixth_prod;

  assign cfg_ready = 1'b1;
  assign in_xfer   = s_tvalid && s_tready;
  assign wr_en     = in_xfer && (bins_loaded < CNT_W'(MAX_BINS));
  assign a_wdata   = {s_tdata[16], s_tdata[15:0]};
  assign b_wdata   = {s_tdata[33], s_tdata[32:17]};

  csp_ram #(.WIDTH(BIN_W), .DEPTH(MAX_BINS)) u_first_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (bins_loaded[IDX_W-1:0]),
    .wdata (a_wdata),
    .raddr (c_idx),
    .rdata (a_q)
  );

  csp_ram #(.WIDTH(BIN_W), .DEPTH(MAX_BINS)) u_second_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (bins_loaded[IDX_W-1:0]),
    .wdata (b_wdata),
    .raddr (bc_idx),
    .rdata (b_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign send_ok = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid && s_tlast) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (c_last && s_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld && !cand_vld) begin
          state_next = found ? ST_DEN : ST_SEND;
        end
      end
      ST_DEN:   state_next = ST_SINIT;
      ST_SINIT: state_next = (best_err < ERR_W'(den)) ? ST_SDIV : ST_YINIT;
      ST_SDIV: begin
        if (div_cnt == '0) begin
          state_next = ST_YINIT;
        end
      end
      ST_YINIT: state_next = ST_YDIV;
      ST_YDIV: begin
        if (div_cnt == '0) begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (send_ok) begin
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_overlap <= CNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      min_overlap <= cfg_data;
    end
  end

  // Frame loading
  always_ff @(posedge clk) begin
    if (rst) begin
      bins_loaded <= '0;
      frame_cnt   <= '0;
    end else if (in_xfer) begin
      if (s_tlast) begin
        bins_loaded <= '0;
        frame_cnt   <= bins_loaded + CNT_W'(wr_en);
      end else if (wr_en) begin
        bins_loaded <= bins_loaded + 1'b1;
      end
    end
  end

  // Address sequencing over shifts and bins
  assign c_last  = ({1'b0, c_idx} == frame_cnt - 1'b1);
  assign s_last  = ({1'b0, s_idx} == frame_cnt - 1'b1);
  assign bc_last = ({1'b0, bc_idx} == frame_cnt - 1'b1);

  always_ff @(posedge clk) begin
    if (state == ST_SEARCH) begin
      if (c_last) begin
        c_idx  <= '0;
        s_idx  <= s_idx + 1'b1;
        bc_idx <= s_idx + 1'b1;
      end else begin
        c_idx  <= c_idx + 1'b1;
        bc_idx <= bc_last ? '0 : bc_idx + 1'b1;
      end
    end else begin
      c_idx  <= '0;
      s_idx  <= '0;
      bc_idx <= '0;
    end
    rd_last  <= c_last;
    rd_shift <= s_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SEARCH);
    end
  end

  // Accumulate error and overlap of one shift
  assign diff        = (a_q[RANGE_BITS-1:0] >= b_q[RANGE_BITS-1:0]) ?
                       a_q[RANGE_BITS-1:0] - b_q[RANGE_BITS-1:0] :
                       b_q[RANGE_BITS-1:0] - a_q[RANGE_BITS-1:0];
  assign both_hit    = a_q[RANGE_BITS] && b_q[RANGE_BITS];
  assign acc_err_sum = acc_err + (both_hit ? ERR_W'(diff) : '0);
  assign acc_n_sum   = acc_n + CNT_W'(both_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_vld <= 1'b0;
    end else begin
      cand_vld <= rd_vld && rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      acc_err <= '0;
      acc_n   <= '0;
    end else if (rd_vld) begin
      if (rd_last) begin
        cand_err   <= acc_err_sum;
        cand_n     <= acc_n_sum;
        cand_shift <= rd_shift;
        acc_err    <= '0;
        acc_n      <= '0;
      end else begin
        acc_err <= acc_err_sum;
        acc_n   <= acc_n_sum;
      end
    end
  end

  // Compare mean errors by cross multiplication; keep the earliest on a tie
  assign sixth_prod = (CNT_W+5)'(frame_cnt) * (CNT_W+5)'(SIXTH_RECIP);
  assign min_n      = CNT_W'(sixth_prod >> SIXTH_SHIFT);
  assign prod_cand  = cand_err * best_n;
  assign prod_best  = best_err * cand_n;
  assign cand_ok    = (cand_n != '0) && (cand_n >= min_n) &&
                      (!found || (prod_cand < prod_best));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (state == ST_LOAD) begin
      found <= 1'b0;
    end else if (cand_vld && cand_ok) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      best_err <= '0;
      best_n   <= '0;
      best_s   <= '0;
    end else if (cand_vld && cand_ok) begin
      best_err <= cand_err;
      best_n   <= cand_n;
      best_s   <= cand_shift;
    end
  end

  // Shared restoring divider for score and yaw
  assign rem_sh   = {div_rem, div_dq[DIV_W-1]};
  assign rem_ge   = rem_sh >= {1'b0, div_den};
  assign rem_step = rem_ge ? DEN_W'(rem_sh - {1'b0, div_den}) : rem_sh[DEN_W-1:0];

  always_ff @(posedge clk) begin
    case (state)
      ST_DEN: begin
        den       <= DEN_W'(best_n * DEN_W'(FULL_SCALE_MM));
        res_score <= '0;
      end
      ST_SINIT: begin
        div_den <= den;
        div_rem <= '0;
        div_dq  <= DIV_W'(den - DEN_W'(best_err)) << Q10_SHIFT;
        div_cnt <= DIV_CNT_W'(DIV_W - 1);
      end
      ST_SDIV, ST_YDIV: begin
        div_rem <= rem_step;
        div_dq  <= {div_dq[DIV_W-2:0], rem_ge};
        div_cnt <= div_cnt - 1'b1;
        if (div_cnt == '0) begin
          if (state == ST_SDIV) begin
            res_score <= SCORE_W'({div_dq[DIV_W-2:0], rem_ge});
          end else begin
            res_yaw <= YAW_W'({div_dq[DIV_W-2:0], rem_ge});
          end
        end
      end
      ST_YINIT: begin
        div_den <= DEN_W'(frame_cnt);
        div_rem <= '0;
        div_dq  <= DIV_W'(best_s) * DIV_W'(YAW_FULL);
        div_cnt <= DIV_CNT_W'(DIV_W - 1);
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_SEND && send_ok) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEND && send_ok) begin
      if (found) begin
        m_tdata <= {6'b0, (best_n >= min_overlap), best_n, res_yaw, best_s,
                    res_score, 1'b1};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  a_overlap_when_matched: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[40:34] != '0))
    else $error("matched result with zero overlap");

  a_unmatched_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata == '0))
    else $error("unmatched result carries nonzero fields");

  a_found_nonzero_n: assert property (@(posedge clk) disable iff (rst)
    (found && state != ST_LOAD) |-> (best_n != '0))
    else $error("best candidate with zero overlap");

  a_bins_bounded: assert property (@(posedge clk) disable iff (rst)
    bins_loaded <= CNT_W'(MAX_BINS))
    else $error("bin count beyond memory depth");

  a_no_cand_in_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> (!rd_vld && !cand_vld))
    else $error("search pipeline active while loading");

endmodule
`default_nettype wire

// File: src/csp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module csp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: bench/circular_shift_profile_match_unit_tb.sv
// Testbench for the circular shift profile match unit: bin streams in, checked rotation matches out.
`timescale 1ns / 100ps
`default_nettype none
module circular_shift_profile_match_unit_tb;
  import csp_pkg::*;

  localparam int OVERLAP_DIV  = 6;
  localparam int Q10_ONE      = 1 << Q10_SHIFT;
  localparam int QUIET_LIMIT  = 40000;
  localparam int SETTLE_CYC   = 16;
  localparam int GEN_MAX_BINS = 80;

  typedef enum int {FR_ROTATED, FR_NOISE, FR_SPARSE} frame_kind_t;

  typedef struct packed {
    logic              usable;
    logic [CNT_W-1:0]  overlap_bins;
    logic [YAW_W-1:0]  yaw_centideg;
    logic [IDX_W-1:0]  best_shift;
    logic [SCORE_W-1:0] score_q10;
    logic              matched;
  } match_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CNT_W-1:0]     cfg_data = '0;

  logic [RANGE_BITS-1:0] held_first_rng [MAX_BINS];
  logic                  held_first_hit [MAX_BINS];
  logic [RANGE_BITS-1:0] held_second_rng [MAX_BINS];
  logic                  held_second_hit [MAX_BINS];
  int unsigned           bins_held = 0;
  logic [CNT_W-1:0]      min_overlap_now = 7'd1;

  match_t pending_matches [$];

  bit src_gaps  = 1'b1;
  bit sink_gaps = 1'b1;
  int fail_count = 0;
  int bins_sent = 0;
  int frames_sent = 0;
  int matches_seen = 0;
  int cfg_writes = 0;
  int quiet_cycles = 0;

  circular_shift_profile_match_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void predict_rotation_match(input logic [RANGE_BITS-1:0] ra,
                                                 input logic ha,
                                                 input logic [RANGE_BITS-1:0] rb,
                                                 input logic hb,
                                                 input logic last);
    int unsigned count, s, c, j, best_s;
    longint unsigned err, n, best_err, best_n, den, score, yaw;
    bit found;
    match_t m;
    if (bins_held < MAX_BINS) begin
      held_first_rng[bins_held]  = ra;
      held_first_hit[bins_held]  = ha;
      held_second_rng[bins_held] = rb;
      held_second_hit[bins_held] = hb;
      bins_held++;
    end
    if (!last) return;
    count = bins_held;
    bins_held = 0;
    found = 1'b0;
    best_err = 0;
    best_n = 0;
    best_s = 0;
    for (s = 0; s < count; s++) begin
      err = 0;
      n = 0;
      for (c = 0; c < count; c++) begin
        j = (c + s) % count;
        if (held_first_hit[c] && held_second_hit[j]) begin
          err += (held_first_rng[c] >= held_second_rng[j]) ?
                 longint'(held_first_rng[c] - held_second_rng[j]) :
                 longint'(held_second_rng[j] - held_first_rng[c]);
          n++;
        end
      end
      if (n != 0 && n >= count / OVERLAP_DIV) begin
        if (!found || err * best_n < best_err * n) begin
          found = 1'b1;
          best_err = err;
          best_n = n;
          best_s = s;
        end
      end
    end
    m = '0;
    if (found) begin
      den = longint'(FULL_SCALE_MM) * best_n;
      score = (best_err < den) ? (longint'(Q10_ONE) * (den - best_err)) / den : 0;
      yaw = (longint'(best_s) * YAW_FULL) / count;
      m.matched      = 1'b1;
      m.score_q10    = score[SCORE_W-1:0];
      m.best_shift   = best_s[IDX_W-1:0];
      m.yaw_centideg = yaw[YAW_W-1:0];
      m.overlap_bins = best_n[CNT_W-1:0];
      m.usable       = (best_n >= min_overlap_now);
    end
    pending_matches.push_back(m);
  endfunction

  task automatic send_bin(input logic [RANGE_BITS-1:0] ra, input logic ha,
                          input logic [RANGE_BITS-1:0] rb, input logic hb,
                          input logic last);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, hb, rb, ha, ra};
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    predict_rotation_match(ra, ha, rb, hb, last);
    bins_sent++;
    if (last) frames_sent++;
  endtask

  // drop valid at the accept edge, then wait out the frame in flight
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_min_overlap(input logic [CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    min_overlap_now = value;
    cfg_writes++;
  endtask

  task automatic send_frame(input int nbins, input frame_kind_t kind);
    logic [RANGE_BITS-1:0] ra [GEN_MAX_BINS];
    logic [RANGE_BITS-1:0] rb [GEN_MAX_BINS];
    logic ha [GEN_MAX_BINS];
    logic hb [GEN_MAX_BINS];
    int rot, span, v, c, j;
    span = ($urandom_range(0, 1) == 1) ? 65535 : 8000;
    rot = $urandom_range(0, nbins - 1);
    for (c = 0; c < nbins; c++) begin
      ra[c] = RANGE_BITS'($urandom_range(0, span));
      case (kind)
        FR_ROTATED: begin
          j = (c + rot) % nbins;
          v = int'(ra[c]) + int'($urandom_range(0, 400)) - 200;
          if (v < 0) v = 0;
          if (v > 65535) v = 65535;
          rb[j] = v[RANGE_BITS-1:0];
          ha[c] = ($urandom_range(0, 9) != 0);
          hb[j] = ($urandom_range(0, 9) != 0);
        end
        FR_NOISE: begin
          rb[c] = RANGE_BITS'($urandom_range(0, 65535));
          ha[c] = 1'($urandom_range(0, 1));
          hb[c] = 1'($urandom_range(0, 1));
        end
        default: begin
          rb[c] = RANGE_BITS'($urandom_range(0, 65535));
          ha[c] = ($urandom_range(0, 6) == 0);
          hb[c] = ($urandom_range(0, 6) == 0);
        end
      endcase
    end
    for (c = 0; c < nbins; c++)
      send_bin(ra[c], ha[c], rb[c], hb[c], c == nbins - 1);
  endtask

  function automatic int pick_bins();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, 12);
    if (r < 9) return $urandom_range(13, 40);
    return $urandom_range(41, MAX_BINS);
  endfunction

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return FR_ROTATED;
    if (r < 17) return FR_NOISE;
    return FR_SPARSE;
  endfunction

  task automatic test_directed_cases();
    // single bin at opposite range extremes
    send_bin(16'd0, 1'b1, 16'hFFFF, 1'b1, 1'b1);
    // single bin with no hits
    send_bin(16'hFFFF, 1'b0, 16'hFFFF, 1'b0, 1'b1);
    // identical full-scale profiles, all shifts tie
    repeat (2) send_bin(16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b0);
    send_bin(16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b1);
    // second profile rotated by one bin
    send_bin(16'd100, 1'b1, 16'd400, 1'b1, 1'b0);
    send_bin(16'd200, 1'b1, 16'd100, 1'b1, 1'b0);
    send_bin(16'd300, 1'b1, 16'd200, 1'b1, 1'b0);
    send_bin(16'd400, 1'b1, 16'd300, 1'b1, 1'b1);
    // overlap below a sixth of the bins at every shift
    send_bin(16'd500, 1'b1, 16'd500, 1'b1, 1'b0);
    for (int c = 1; c < 12; c++)
      send_bin(16'h5555, 1'b0, 16'hAAAA, 1'b0, c == 11);
    settle();
  endtask

  task automatic test_min_overlap_settings();
    logic [CNT_W-1:0] settings [5];
    settings = '{7'd0, 7'd64, 7'd1, 7'd12, 7'd0};
    foreach (settings[k]) begin
      write_min_overlap(settings[k]);
      send_frame(MAX_BINS, FR_ROTATED);
      send_frame($urandom_range(8, 24), FR_SPARSE);
      send_frame($urandom_range(1, 16), pick_kind());
      settle();
    end
    write_min_overlap(CNT_W'($urandom_range(0, 64)));
  endtask

  task automatic test_random_frames();
    int frame_no;
    frame_no = 0;
    while (bins_sent < 1500) begin
      send_frame(pick_bins(), pick_kind());
      frame_no++;
      if (frame_no % 12 == 0) begin
        settle();
        write_min_overlap(CNT_W'($urandom_range(0, 64)));
      end
    end
    settle();
  endtask

  task automatic test_bin_overflow();
    send_frame(MAX_BINS + 1, FR_ROTATED);
    send_frame($urandom_range(MAX_BINS + 2, GEN_MAX_BINS), FR_NOISE);
    send_frame(GEN_MAX_BINS, FR_ROTATED);
    settle();
  endtask

  task automatic test_back_to_back();
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    write_min_overlap(7'd1);
    repeat (14) send_frame($urandom_range(1, 20), pick_kind());
    send_frame(MAX_BINS, FR_ROTATED);
    settle();
  endtask

  initial begin
    m_tready <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_gaps && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_matches
    match_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = match_t'(m_tdata[$bits(match_t)-1:0]);
      matches_seen++;
      if (pending_matches.size() == 0) begin
        $error("unexpected result transfer: %h", m_tdata);
        fail_count++;
      end else begin
        want = pending_matches.pop_front();
        if (got.matched !== want.matched) begin
          $error("matched: expected %0d, actual %0d", want.matched, got.matched);
          fail_count++;
        end
        if (got.score_q10 !== want.score_q10) begin
          $error("score_q10: expected %0d, actual %0d", want.score_q10, got.score_q10);
          fail_count++;
        end
        if (got.best_shift !== want.best_shift) begin
          $error("best_shift: expected %0d, actual %0d", want.best_shift, got.best_shift);
          fail_count++;
        end
        if (got.yaw_centideg !== want.yaw_centideg) begin
          $error("yaw_centideg: expected %0d, actual %0d", want.yaw_centideg,
                 got.yaw_centideg);
          fail_count++;
        end
        if (got.overlap_bins !== want.overlap_bins) begin
          $error("overlap_bins: expected %0d, actual %0d", want.overlap_bins,
                 got.overlap_bins);
          fail_count++;
        end
        if (got.usable !== want.usable) begin
          $error("usable: expected %0d, actual %0d", want.usable, got.usable);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_matches.size());
        $display("circular_shift_profile_match_unit_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    @(negedge rst);
    @(posedge clk);
    test_directed_cases();
    test_min_overlap_settings();
    test_random_frames();
    test_bin_overflow();
    test_back_to_back();
    repeat (100) @(posedge clk);
    $display("covered %0d bins in %0d frames with %0d min_overlap writes,",
             bins_sent, frames_sent, cfg_writes);
    $display("including no-match, tie, overflow and full-size frames; %0d results checked",
             matches_seen);
    if (fail_count == 0 && pending_matches.size() == 0) begin
      $display("circular_shift_profile_match_unit_tb: PASS");
    end else begin
      $display("circular_shift_profile_match_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
